// ----- hdl/gbci_pkg.sv -----
// ----------------------------------------------------------------------------
// gbci_pkg: shared types and constants
// Word types, configuration register indexes, reset values and the status
// struct of the shared serial divider.
// ----------------------------------------------------------------------------
package gbci_pkg;

    // Default fraction width of the 12.F position registers
    localparam int GBCI_POS_FRAC_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_DIVIDER      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIBRATION_COUNT = 1'd1;

    localparam logic [15:0] RATE_DIVIDER_RESET      = 16'd64;
    localparam logic [15:0] CALIBRATION_COUNT_RESET = 16'd1000;

    // s16.8 offset limits
    localparam logic [23:0] OFFSET_MAX = 24'h7F_FFFF;
    localparam logic [23:0] OFFSET_MIN = 24'h80_0000;

    // Divisor width: rate_divider * 256 fits in 24 bits
    localparam int DIV_DSR_W = 24;

    // Input word
    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic               recalibrate;
    } gbci_in_t;

    // Output word
    typedef struct packed {
        logic [11:0] duty_x;
        logic [11:0] duty_y;
        logic [11:0] duty_z;
        logic        calibrating;
    } gbci_out_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } gbci_div_stat_t;

endpackage

// ----- hdl/gbci_stream_if.sv -----
// ----------------------------------------------------------------------------
// gbci_stream_if: valid/ready channel
// Carries one payload word per handshake; a word moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface gbci_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gyro_bias_calibrate_integrate.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate: gyro bias calibration and rate integration
// Averages a run of samples into per-axis s16.8 offsets, then integrates the
// corrected, scaled rate into clamped 12.F positions given out as PWM duties.
// ----------------------------------------------------------------------------
// Sequence: an accepted word passes S_START; a calibration word that does not
//   end the run goes on to S_OUT, any other word first runs one serial divider,
//   shared across the three axes, once per axis before S_OUT.
// Flow: a new word is taken only in S_IDLE, once the last one is through;
//   S_OUT waits while a result still sits in the output register.
// Reset: positions 2047.0, offsets, sums, count zero; registers 64 and 1000.
module gyro_bias_calibrate_integrate
    import gbci_pkg::*;
#(
    parameter int POSITION_FRACTION_BITS = GBCI_POS_FRAC_BITS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    gbci_stream_if.sink            in_ch,
    gbci_stream_if.source          out_ch
);

    localparam int F      = POSITION_FRACTION_BITS;
    localparam int POS_W  = 12 + F;
    localparam int STEP_W = F + 18;
    localparam int DVD_W  = (F + 24 > 39) ? F + 24 : 39;

    localparam logic [POS_W-1:0] POS_TOP = {12'd4095, {F{1'b0}}};
    localparam logic [POS_W-1:0] POS_MID = {12'd2047, {F{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV_INIT,
        S_DIV_WAIT,
        S_DIV_DONE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]      s_reg   [3];
    logic [15:0]      s_next  [3];
    logic [POS_W-1:0] pos_reg [3];
    logic [POS_W-1:0] pos_next[3];
    logic [23:0]      off_reg [3];
    logic [23:0]      off_next[3];
    logic [32:0]      sum_reg [3];
    logic [32:0]      sum_next[3];

    logic        recal_reg, recal_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] rdiv_reg, rdiv_next;
    logic [15:0] ccnt_reg, ccnt_next;
    logic        mode_off_reg, mode_off_next;
    logic [1:0]  axis_reg, axis_next;
    logic        neg_reg, neg_next;
    logic        out_valid_reg, out_valid_next;
    gbci_out_t   out_data_reg, out_data_next;

    // Divider hookup
    logic                 div_start;
    logic [DVD_W-1:0]     div_dividend;
    logic [DIV_DSR_W-1:0] div_divisor;
    logic [DVD_W-1:0]     div_quotient;
    gbci_div_stat_t       div_stat;

    // Decode and operand signals
    logic [15:0]      eff_div;
    logic [15:0]      eff_cnt;
    logic             restart;
    logic [15:0]      left_eff;
    logic [24:0]      int_diff;
    logic [24:0]      int_mag;
    logic             int_neg;
    logic [32:0]      sum_sel;
    logic [32:0]      sum_mag;
    logic             sum_neg;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] psum;
    logic [POS_W-1:0] pos_clamped;
    logic [23:0]      off_sat;

    gbci_div #(
        .DVD_W (DVD_W),
        .DSR_W (DIV_DSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Register decode and restart decision
    always_comb
    begin
        eff_div  = (rdiv_reg == 16'd0) ? 16'd1 : rdiv_reg;
        eff_cnt  = (ccnt_reg == 16'd0) ? 16'd1 : ccnt_reg;
        restart  = recal_reg ||
                   (left_reg == 16'd0 && off_reg[0] == 24'd0 &&
                    off_reg[1] == 24'd0 && off_reg[2] == 24'd0);
        left_eff = restart ? eff_cnt : left_reg;
    end

    // Divider operands for the current axis
    always_comb
    begin
        // integrate: (s * 256 - offset) << F over divider * 256
        int_diff = {s_reg[axis_reg][15], s_reg[axis_reg], 8'h00} -
                   {off_reg[axis_reg][23], off_reg[axis_reg]};
        int_neg  = int_diff[24];
        int_mag  = int_neg ? (25'd0 - int_diff) : int_diff;

        // offset: sum * 256 over count; |sum| stays below 2^31
        sum_sel  = sum_reg[axis_reg];
        sum_neg  = sum_sel[32];
        sum_mag  = sum_neg ? (33'd0 - sum_sel) : sum_sel;

        if (mode_off_reg)
        begin
            div_dividend = DVD_W'(sum_mag[30:0]) << 8;
            div_divisor  = DIV_DSR_W'(eff_cnt);
        end
        else
        begin
            div_dividend = DVD_W'(int_mag[23:0]) << F;
            div_divisor  = {eff_div, 8'h00};
        end
    end

    // Apply the signed quotient: clamp the position, saturate the offset
    always_comb
    begin
        step = neg_reg ? (STEP_W'(0) - STEP_W'(div_quotient[F+15:0]))
                       : STEP_W'(div_quotient[F+15:0]);
        psum = STEP_W'(pos_reg[axis_reg]) + step;
        if (psum[STEP_W-1])
            pos_clamped = '0;
        else if (psum > STEP_W'(POS_TOP))
            pos_clamped = POS_TOP;
        else
            pos_clamped = psum[POS_W-1:0];

        if (!neg_reg)
            off_sat = (div_quotient > DVD_W'(OFFSET_MAX)) ? OFFSET_MAX
                                                          : div_quotient[23:0];
        else
            off_sat = (div_quotient > DVD_W'(OFFSET_MIN)) ? OFFSET_MIN
                                                          : (24'd0 - div_quotient[23:0]);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        recal_next     = recal_reg;
        left_next      = left_reg;
        rdiv_next      = rdiv_reg;
        ccnt_next      = ccnt_reg;
        mode_off_next  = mode_off_reg;
        axis_next      = axis_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            s_next[i]   = s_reg[i];
            pos_next[i] = pos_reg[i];
            off_next[i] = off_reg[i];
            sum_next[i] = sum_reg[i];
        end

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RATE_DIVIDER:      rdiv_next = cfg_data;
                CFG_CALIBRATION_COUNT: ccnt_next = cfg_data;
                default:               ;
            endcase
        end

        // output word taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    s_next[0]  = in_ch.data.rate_x;
                    s_next[1]  = in_ch.data.rate_y;
                    s_next[2]  = in_ch.data.rate_z;
                    recal_next = in_ch.data.recalibrate;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                axis_next = 2'd0;
                if (restart)
                begin
                    for (int i = 0; i < 3; i++)
                        pos_next[i] = POS_MID;
                end
                if (left_eff == 16'd0)
                begin
                    mode_off_next = 1'b0;
                    state_next    = S_DIV_INIT;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        sum_next[i] = (restart ? 33'd0 : sum_reg[i]) +
                                      {{17{s_reg[i][15]}}, s_reg[i]};
                    left_next = left_eff - 16'd1;
                    if (left_eff == 16'd1)
                    begin
                        mode_off_next = 1'b1;
                        state_next    = S_DIV_INIT;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_DIV_INIT:
            begin
                div_start  = 1'b1;
                neg_next   = mode_off_reg ? sum_neg : int_neg;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_DIV_DONE;
            end

            S_DIV_DONE:
            begin
                if (mode_off_reg)
                    off_next[axis_reg] = off_sat;
                else
                    pos_next[axis_reg] = pos_clamped;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.duty_x      = pos_reg[0][POS_W-1 -: 12];
                    out_data_next.duty_y      = pos_reg[1][POS_W-1 -: 12];
                    out_data_next.duty_z      = pos_reg[2][POS_W-1 -: 12];
                    out_data_next.calibrating = (left_reg != 16'd0);
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= 16'd0;
            rdiv_reg      <= RATE_DIVIDER_RESET;
            ccnt_reg      <= CALIBRATION_COUNT_RESET;
            mode_off_reg  <= 1'b0;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= POS_MID;
                off_reg[i] <= 24'd0;
                sum_reg[i] <= 33'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            rdiv_reg      <= rdiv_next;
            ccnt_reg      <= ccnt_next;
            mode_off_reg  <= mode_off_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
                off_reg[i] <= off_next[i];
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    // Word and operand holding, no reset
    always_ff @(posedge clk)
    begin
        recal_reg    <= recal_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 3; i++)
            s_reg[i] <= s_next[i];
    end

    // Positions never leave 0..4095.0
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg[0] <= POS_TOP && pos_reg[1] <= POS_TOP && pos_reg[2] <= POS_TOP)
        else $error("position beyond full scale");

    // Positions hold while calibration samples remain
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_START && left_reg != 16'd0) |=>
            ($stable(pos_reg[0]) && $stable(pos_reg[1]) && $stable(pos_reg[2])))
        else $error("position moved during calibration");

    // Divider only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // Calibrating flag follows the sample count
    a_cal_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || out_ch.ready)) |=>
            (out_ch.valid && out_ch.data.calibrating == (left_reg != 16'd0)))
        else $error("calibrating flag disagrees with sample count");

endmodule

// ----- hdl/gbci_div.sv -----
// ----------------------------------------------------------------------------
// gbci_div: serial restoring divider
// Unsigned magnitude division, one quotient bit per cycle. The quotient is
// held after done until the next start.
// ----------------------------------------------------------------------------
module gbci_div
    import gbci_pkg::*;
#(
    parameter int DVD_W = 40,
    parameter int DSR_W = DIV_DSR_W
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output gbci_div_stat_t   stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] trial;

    // One restoring step: shift in the next dividend bit, try a subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dsr_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DSR_W+1])
            begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sim/gyro_bias_calibrate_integrate_tb.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_tb: self-checking bench for the gyro block
// Sends rate words through calibration and integration runs under several
// register settings. An in-bench model predicts every duty word, and the
// bench compares each one in order as it leaves the block.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_tb
    import gbci_pkg::*;
();

    localparam int     POS_F         = GBCI_POS_FRAC_BITS;
    localparam longint POS_ONE       = longint'(1) << POS_F;
    localparam int     TOTAL_WORDS   = 1150;
    localparam int     CYCLE_LIMIT   = 1_500_000;
    localparam int     SETTLE_CYCLES = 200;
    localparam int     LONG_HOLD     = 600;
    localparam int     HOLD_AT_WORD  = 500;
    localparam int     MAX_REPORTS   = 10;

    typedef enum int {
        IDLE_SEND_LIGHT,   // sender 26 %, receiver 79 %
        IDLE_SEND_HEAVY,   // sender 79 %, receiver 26 %
        IDLE_NONE
    } idle_mode_t;

    // ------------------------------------------------------------------------
    // Duty predictor and in-order checker
    // ------------------------------------------------------------------------
    class gyro_duty_board;
        logic [CFG_DATA_W-1:0] rate_divider;
        logic [CFG_DATA_W-1:0] calib_count;
        longint                position [3];
        longint                offset   [3];
        longint                rate_sum [3];
        int                    samples_left;
        gbci_out_t             pending_duties [$];
        int                    mismatches;

        function new();
            rate_divider = RATE_DIVIDER_RESET;
            calib_count  = CALIBRATION_COUNT_RESET;
            for (int a = 0; a < 3; a++)
            begin
                position[a] = 2047 * POS_ONE;
                offset[a]   = 0;
                rate_sum[a] = 0;
            end
            samples_left = 0;
            mismatches   = 0;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [CFG_DATA_W-1:0] value);
            if (index == CFG_RATE_DIVIDER)
                rate_divider = value;
            else if (index == CFG_CALIBRATION_COUNT)
                calib_count = value;
        endfunction

        // Advance the model by one accepted rate word and queue its duties
        function void note_sample(input gbci_in_t w);
            longint    rate [3];
            longint    den;
            longint    top;
            longint    p;
            longint    o;
            longint    c;
            gbci_out_t duties;
            rate[0] = longint'($signed(w.rate_x));
            rate[1] = longint'($signed(w.rate_y));
            rate[2] = longint'($signed(w.rate_z));

            // restart on request, or when idle with no offsets at all
            if (w.recalibrate ||
                (samples_left == 0 && offset[0] == 0 && offset[1] == 0 && offset[2] == 0))
            begin
                for (int a = 0; a < 3; a++)
                begin
                    position[a] = 2047 * POS_ONE;
                    rate_sum[a] = 0;
                end
                samples_left = (calib_count == 0) ? 1 : int'(calib_count);
            end

            if (samples_left == 0)
            begin
                // integrate the corrected rate, clamped to the duty range
                den = longint'((rate_divider == 0) ? 16'd1 : rate_divider) * 256;
                top = 4095 * POS_ONE;
                for (int a = 0; a < 3; a++)
                begin
                    p = position[a] + ((rate[a] * 256 - offset[a]) * POS_ONE) / den;
                    if (p < 0)
                        p = 0;
                    if (p > top)
                        p = top;
                    position[a] = p;
                end
            end
            else
            begin
                // gather the run; offsets use the count register as it is now
                for (int a = 0; a < 3; a++)
                    rate_sum[a] += rate[a];
                samples_left--;
                if (samples_left == 0)
                begin
                    c = (calib_count == 0) ? 1 : longint'(calib_count);
                    for (int a = 0; a < 3; a++)
                    begin
                        o = (rate_sum[a] * 256) / c;
                        if (o > longint'($signed(OFFSET_MAX)))
                            o = longint'($signed(OFFSET_MAX));
                        if (o < longint'($signed(OFFSET_MIN)))
                            o = longint'($signed(OFFSET_MIN));
                        offset[a] = o;
                    end
                end
            end

            duties.duty_x      = 12'(position[0] >> POS_F);
            duties.duty_y      = 12'(position[1] >> POS_F);
            duties.duty_z      = 12'(position[2] >> POS_F);
            duties.calibrating = (samples_left != 0);
            pending_duties.push_back(duties);
        endfunction

        function void check_duties(input gbci_out_t got);
            gbci_out_t want;
            if (pending_duties.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("duty word x=%0d y=%0d z=%0d cal=%0b arrived with none pending",
                             got.duty_x, got.duty_y, got.duty_z, got.calibrating);
                return;
            end
            want = pending_duties.pop_front();
            if (got.duty_x !== want.duty_x || got.duty_y !== want.duty_y ||
                got.duty_z !== want.duty_z || got.calibrating !== want.calibrating)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("duty mismatch: x %0d/%0d y %0d/%0d z %0d/%0d cal %0b/%0b (exp/got)",
                             want.duty_x, got.duty_x, want.duty_y, got.duty_y,
                             want.duty_z, got.duty_z, want.calibrating, got.calibrating);
            end
        endfunction

        function int pending();
            return pending_duties.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (pending_duties.size() == 0);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, signals and block
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gbci_stream_if #(.payload_t(gbci_in_t))  in_ch ();
    gbci_stream_if #(.payload_t(gbci_out_t)) out_ch ();

    gyro_duty_board board;
    idle_mode_t     idle_mode   = IDLE_SEND_LIGHT;
    int             words_in    = 0;
    int             cycle_count = 0;
    int             hold_left   = 0;
    bit             hold_done   = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gyro_bias_calibrate_integrate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // ------------------------------------------------------------------------
    // Result side: check every word taken, random back-pressure
    // ------------------------------------------------------------------------
    initial out_ch.ready = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_duties(out_ch.data);
            if (hold_left > 0)
                out_ch.ready <= 1'b0;
            else if (idle_mode == IDLE_NONE)
                out_ch.ready <= 1'b1;
            else if (idle_mode == IDLE_SEND_LIGHT)
                out_ch.ready <= ($urandom_range(99) >= 79);
            else
                out_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    // One long receiver hold, started while the sender is offering
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && words_in >= HOLD_AT_WORD && in_ch.valid)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic gbci_in_t make_word(input int x, input int y, input int z,
                                           input bit recal);
        gbci_in_t w;
        w.rate_x      = sat16(x);
        w.rate_y      = sat16(y);
        w.rate_z      = sat16(z);
        w.recalibrate = recal;
        return w;
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    // One register write; returns only after the lowered enable is sampled, so
    // back-to-back writes never lower and raise the enable in the same step
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(index, value);
        @(posedge clk);
    endtask

    // Offer one rate word, with a random gap first, until the block takes it
    task automatic send_word(input gbci_in_t w);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND_LIGHT) ? 26 :
                  (idle_mode == IDLE_SEND_HEAVY) ? 79 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_sample(w);
        words_in++;
    endtask

    // Stop offering and wait for every predicted duty word
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        gbci_in_t              w;
        logic [CFG_DATA_W-1:0] div_val;
        logic [CFG_DATA_W-1:0] cnt_val;
        int                    pick;
        int                    spread;
        int                    n_cal;
        int                    n_run;
        int                    bias  [3];
        int                    drift [3];
        bit                    quiet;

        board       = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fastest divider, two-sample run at the rate extremes; the zero
        // offsets left by reset start the run without a request
        write_register(CFG_RATE_DIVIDER, 16'd1);
        write_register(CFG_CALIBRATION_COUNT, 16'd2);
        send_word(make_word(32767, -32768, 0, 1'b0));
        send_word(make_word(32767, -32768, 1, 1'b0));
        send_word(make_word(-32768, 32767, 0, 1'b0));
        send_word(make_word(32767, -32768, -1, 1'b0));

        // divider of zero acts as one
        wait_drained();
        write_register(CFG_RATE_DIVIDER, 16'd0);
        send_word(make_word(-1, 1, 32767, 1'b0));
        send_word(make_word(0, 0, -32768, 1'b0));

        // slowest divider; count of zero acts as one; a zero mean restarts
        wait_drained();
        write_register(CFG_RATE_DIVIDER, 16'hFFFF);
        write_register(CFG_CALIBRATION_COUNT, 16'd0);
        send_word(make_word(0, 0, 0, 1'b1));
        send_word(make_word(100, -5, 3, 1'b0));
        send_word(make_word(30000, -30000, 12345, 1'b0));
        send_word(make_word(-30000, 30000, -12345, 1'b0));

        // count lowered mid-run: the sums divide by the new count and the
        // offsets saturate both ways
        wait_drained();
        write_register(CFG_CALIBRATION_COUNT, 16'd4);
        send_word(make_word(32767, -32768, 32767, 1'b1));
        send_word(make_word(32767, -32768, 32767, 1'b0));
        wait_drained();
        write_register(CFG_CALIBRATION_COUNT, 16'd1);
        send_word(make_word(32767, -32768, -32768, 1'b0));
        send_word(make_word(32767, -32768, -32768, 1'b0));
        send_word(make_word(0, 0, 0, 1'b0));

        // largest count: a restart that stays calibrating
        wait_drained();
        write_register(CFG_CALIBRATION_COUNT, 16'hFFFF);
        send_word(make_word(1, 2, 3, 1'b1));
        send_word(make_word(-1, -2, -3, 1'b0));

        // random runs, each under fresh register settings
        while (words_in < TOTAL_WORDS)
        begin
            if (words_in < TOTAL_WORDS / 3)
                idle_mode = IDLE_SEND_LIGHT;
            else if (words_in < 2 * TOTAL_WORDS / 3)
                idle_mode = IDLE_SEND_HEAVY;
            else
                idle_mode = IDLE_NONE;

            wait_drained();
            pick = $urandom_range(99);
            if (pick < 5)
                div_val = 16'd0;
            else if (pick < 10)
                div_val = 16'd1;
            else if (pick < 15)
                div_val = 16'hFFFF;
            else if (pick < 25)
                div_val = 16'($urandom);
            else
                div_val = 16'($urandom_range(512, 2));
            write_register(CFG_RATE_DIVIDER, div_val);

            pick = $urandom_range(99);
            if (pick < 5)
                cnt_val = 16'd0;
            else if (pick < 10)
                cnt_val = 16'd1;
            else if (pick < 15)
                cnt_val = 16'($urandom_range(60, 20));
            else
                cnt_val = 16'($urandom_range(8, 2));
            write_register(CFG_CALIBRATION_COUNT, cnt_val);
            n_cal = (cnt_val == 0) ? 1 : int'(cnt_val);

            if ($urandom_range(99) < 85)
            begin
                // well-formed: requested restart, full run, then integration
                quiet  = ($urandom_range(99) < 5);
                pick   = $urandom_range(2);
                spread = quiet ? 0 : (pick == 0) ? 4 : (pick == 1) ? 64 : 1024;
                for (int a = 0; a < 3; a++)
                begin
                    bias[a]  = quiet ? 0 : int'($urandom_range(8000)) - 4000;
                    drift[a] = int'($urandom_range(12000)) - 6000;
                end
                for (int k = 0; k < n_cal; k++)
                    send_word(make_word(bias[0] + jitter(spread), bias[1] + jitter(spread),
                                        bias[2] + jitter(spread), k == 0));
                n_run = $urandom_range(16, 3);
                for (int k = 0; k < n_run; k++)
                    send_word(make_word(bias[0] + drift[0] + jitter(spread),
                                        bias[1] + drift[1] + jitter(spread),
                                        bias[2] + drift[2] + jitter(spread), 1'b0));
            end
            else
            begin
                // noise: any rate, stray restart requests
                n_run = $urandom_range(12, 4);
                for (int k = 0; k < n_run; k++)
                begin
                    w.rate_x      = 16'($urandom);
                    w.rate_y      = 16'($urandom);
                    w.rate_z      = 16'($urandom);
                    w.recalibrate = ($urandom_range(99) < 15);
                    send_word(w);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.clean())
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
